/* sv/weighted_f1_score_engine_unit_assert.svh */
// Assertion macros for the weighted F1 score engine checkers.
// Both macros expect clk and rst_n in the scope where they are used.
`ifndef WEIGHTED_F1_SCORE_ENGINE_UNIT_ASSERT_SVH
`define WEIGHTED_F1_SCORE_ENGINE_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define F1S_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define F1S_ASSERT_NEXT(lbl, ante, cons, msg) \
    `F1S_ASSERT_CLK(lbl, ante |=> cons, msg)

`endif

/* sv/f1s_pkg.sv */
// Shared constants, payload types and inter-module structs for the
// weighted F1 score engine. No dependencies.
package f1s_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int COUNT_BITS  = 24;
    localparam int CLASS_BITS  = $clog2(MAX_CLASSES);
    localparam int NCLS_W      = $clog2(MAX_CLASSES + 1);
    localparam int CFG_W       = 5;
    localparam int FRAC_BITS   = 16;
    localparam int SCORE_W     = FRAC_BITS + 1;
    // hits*true scaled by 2*2^FRAC_BITS, and the divisor pre-shifted by FRAC_BITS
    localparam int PROD_W      = 2 * COUNT_BITS + 1;
    localparam int NUM_W       = 2 * COUNT_BITS + FRAC_BITS + 1;
    localparam int STEP_W      = $clog2(SCORE_W);

    typedef logic [CLASS_BITS-1:0] class_idx_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        class_idx_t true_class;
        class_idx_t predicted_class;
        logic       has_sample;
        logic       last;
    } sample_t;

    typedef struct packed {
        logic [SCORE_W-1:0] f1_score;
        count_t             samples_used;
        logic               dropped;
    } result_t;

    typedef struct packed {
        logic       inc;
        logic       drop;
        logic       clear;
        class_idx_t true_class;
        class_idx_t predicted_class;
    } store_ctl_t;

    typedef struct packed {
        count_t hit;
        count_t tru;
        count_t pred;
    } store_rd_t;

    typedef struct packed {
        count_t total;
        logic   full;
        logic   dropped;
    } store_stat_t;

    typedef struct packed {
        logic               done;
        logic [SCORE_W-1:0] score;
    } score_stat_t;

endpackage

/* sv/f1s_store.sv */
// Per-class hit/true/predicted counters, sample total and sticky drop flag.
// Depends on f1s_pkg.
module f1s_store
    import f1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_ctl_t  ctl,
    input  class_idx_t  rd_idx,
    output store_rd_t   rd,
    output store_stat_t stat
);

    count_t hit_reg  [MAX_CLASSES];
    count_t true_reg [MAX_CLASSES];
    count_t pred_reg [MAX_CLASSES];
    count_t hit_next [MAX_CLASSES];
    count_t true_next[MAX_CLASSES];
    count_t pred_next[MAX_CLASSES];
    count_t total_reg;
    count_t total_next;
    logic   dropped_reg;
    logic   dropped_next;

    // Each entry has its own incrementer; no per-class count can pass total.
    always_comb
    begin
        for (int i = 0; i < MAX_CLASSES; i++)
        begin
            hit_next[i]  = hit_reg[i];
            true_next[i] = true_reg[i];
            pred_next[i] = pred_reg[i];
            if (ctl.clear)
            begin
                hit_next[i]  = '0;
                true_next[i] = '0;
                pred_next[i] = '0;
            end
            else if (ctl.inc)
            begin
                if (ctl.true_class == CLASS_BITS'(i))
                begin
                    true_next[i] = true_reg[i] + 1'b1;
                    if (ctl.true_class == ctl.predicted_class)
                    begin
                        hit_next[i] = hit_reg[i] + 1'b1;
                    end
                end
                if (ctl.predicted_class == CLASS_BITS'(i))
                begin
                    pred_next[i] = pred_reg[i] + 1'b1;
                end
            end
        end
        total_next   = total_reg;
        dropped_next = dropped_reg;
        if (ctl.clear)
        begin
            total_next   = '0;
            dropped_next = 1'b0;
        end
        else
        begin
            if (ctl.inc)
            begin
                total_next = total_reg + 1'b1;
            end
            if (ctl.drop)
            begin
                dropped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                hit_reg[i]  <= '0;
                true_reg[i] <= '0;
                pred_reg[i] <= '0;
            end
            total_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < MAX_CLASSES; i++)
            begin
                hit_reg[i]  <= hit_next[i];
                true_reg[i] <= true_next[i];
                pred_reg[i] <= pred_next[i];
            end
            total_reg   <= total_next;
            dropped_reg <= dropped_next;
        end
    end

    assign rd.hit       = hit_reg[rd_idx];
    assign rd.tru       = true_reg[rd_idx];
    assign rd.pred      = pred_reg[rd_idx];
    assign stat.total   = total_reg;
    assign stat.full    = (total_reg == '1);
    assign stat.dropped = dropped_reg;

endmodule

/* sv/f1s_score.sv */
// Scoring sequencer: walks the classes with one shared multiplier and a
// restoring divider, one quotient bit per cycle. Depends on f1s_pkg.
module f1s_score
    import f1s_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        ack,
    input  store_rd_t   rd,
    input  count_t      total,
    output class_idx_t  rd_idx,
    output score_stat_t stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_NUM,
        S_MUL_DEN,
        S_DIV,
        S_NEXT,
        S_DONE
    } state_t;

    state_t                  state_reg;
    class_idx_t              cls_reg;
    logic [SCORE_W-1:0]      sum_reg;
    logic [SCORE_W-1:0]      q_reg;
    logic [NUM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        div_reg;
    logic [STEP_W-1:0]       step_reg;

    logic [COUNT_BITS:0]     mul_a;
    count_t                  mul_b;
    logic [PROD_W-1:0]       prod;
    logic                    fits;

    // Shared multiplier: hits*true first, then (true+pred)*total.
    always_comb
    begin
        if (state_reg == S_MUL_NUM)
        begin
            mul_a = {1'b0, rd.hit};
            mul_b = rd.tru;
        end
        else
        begin
            mul_a = {1'b0, rd.tru} + {1'b0, rd.pred};
            mul_b = total;
        end
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign fits = (rem_reg >= div_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cls_reg   <= '0;
            sum_reg   <= '0;
            q_reg     <= '0;
            rem_reg   <= '0;
            div_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cls_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_MUL_NUM;
                    end
                end
                S_MUL_NUM:
                begin
                    q_reg <= '0;
                    if (rd.hit == '0)
                    begin
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        // numerator = 2 * hits * true * 2^FRAC_BITS
                        rem_reg   <= {prod[PROD_W-2:0], {(FRAC_BITS + 1){1'b0}}};
                        state_reg <= S_MUL_DEN;
                    end
                end
                S_MUL_DEN:
                begin
                    div_reg   <= {prod, {FRAC_BITS{1'b0}}};
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // quotient never exceeds 2^FRAC_BITS, so SCORE_W bits suffice
                    if (fits)
                    begin
                        rem_reg <= rem_reg - div_reg;
                    end
                    q_reg    <= {q_reg[SCORE_W-2:0], fits};
                    div_reg  <= div_reg >> 1;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SCORE_W - 1))
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    sum_reg <= sum_reg + q_reg;
                    if (cls_reg == CLASS_BITS'(MAX_CLASSES - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cls_reg   <= cls_reg + 1'b1;
                        state_reg <= S_MUL_NUM;
                    end
                end
                S_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rd_idx     = cls_reg;
    assign stat.done  = (state_reg == S_DONE);
    assign stat.score = sum_reg;

endmodule

/* sv/weighted_f1_score_engine_unit.sv */
// Weighted F1 score engine: one sample transfer per cycle while counting.
// A transfer with last blocks input for 16 class passes: a class without hits
// skips to the add, one with hits takes two multiplies, 17 divide steps and an add;
// the result is registered once all passes are done and the output is not stalled.
// Reset (async, active low) clears all counts, the drop flag and the output;
// class_count returns to 2. Depends on f1s_pkg, f1s_store, f1s_score.
module weighted_f1_score_engine_unit
    import f1s_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             class_count_we,
    input  logic [CFG_W-1:0] class_count_data,
    input  logic             sample_valid,
    output logic             sample_stall,
    input  sample_t          sample,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result
);

    logic [CFG_W-1:0]  class_count_reg;
    logic [NCLS_W-1:0] ncls;
    logic              busy_reg;
    logic              result_valid_reg;
    result_t           result_reg;

    logic              accept;
    logic              bad;
    logic              ack;
    store_ctl_t        ctl;
    store_rd_t         rd;
    store_stat_t       st;
    score_stat_t       sc;
    class_idx_t        rd_idx;

    always_comb
    begin
        priority if (int'(class_count_reg) < 2)
        begin
            ncls = NCLS_W'(2);
        end
        else if (int'(class_count_reg) > MAX_CLASSES)
        begin
            ncls = NCLS_W'(MAX_CLASSES);
        end
        else
        begin
            ncls = NCLS_W'(class_count_reg);
        end
    end

    assign accept = sample_valid && !sample_stall;
    assign bad    = (NCLS_W'(sample.true_class) >= ncls)
                 || (NCLS_W'(sample.predicted_class) >= ncls)
                 || st.full;
    assign ack    = sc.done && (!result_valid_reg || !result_stall);

    assign ctl.inc             = accept && sample.has_sample && !bad;
    assign ctl.drop            = accept && sample.has_sample && bad;
    assign ctl.clear           = ack;
    assign ctl.true_class      = sample.true_class;
    assign ctl.predicted_class = sample.predicted_class;

    f1s_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rd_idx (rd_idx),
        .rd     (rd),
        .stat   (st)
    );

    f1s_score u_score (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept && sample.last),
        .ack    (ack),
        .rd     (rd),
        .total  (st.total),
        .rd_idx (rd_idx),
        .stat   (sc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg  <= CFG_W'(2);
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (class_count_we)
            begin
                class_count_reg <= class_count_data;
            end
            if (accept && sample.last)
            begin
                busy_reg <= 1'b1;
            end
            else if (ack)
            begin
                busy_reg <= 1'b0;
            end
            if (ack)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // counts are still intact at the edge that clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (ack)
        begin
            result_reg.f1_score     <= sc.score;
            result_reg.samples_used <= st.total;
            result_reg.dropped      <= st.dropped;
        end
    end

    assign sample_stall = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sv/f1s_checker.sv */
// Port-level checker for the weighted F1 score engine, bound to the top.
// Depends on f1s_pkg and weighted_f1_score_engine_unit_assert.svh.
`include "weighted_f1_score_engine_unit_assert.svh"

module f1s_checker
    import f1s_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_stall,
    input sample_t sample,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    `F1S_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
    `F1S_ASSERT_CLK(a_score_range, result_valid |-> (int'(result.f1_score) <= (1 << FRAC_BITS)), "score above 1.0")
    `F1S_ASSERT_CLK(a_empty_zero, result_valid && (result.samples_used == '0) |-> (result.f1_score == '0), "empty set scored")
    `F1S_ASSERT_NEXT(a_last_blocks, sample_valid && !sample_stall && sample.last, sample_stall, "input open during scoring")
    `F1S_ASSERT_CLK(a_result_after_busy, $rose(result_valid) |-> $past(sample_stall), "result without a scoring pass")

endmodule

bind weighted_f1_score_engine_unit f1s_checker u_f1s_checker (.*);
